FILE: sv/assert_macros.svh
// Assertion helper macros shared by the smoother RTL.
// Requires a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tmfts_pkg.sv
// Shared types and constants of the trimmed-mean frame time smoother.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package tmfts_pkg;

  localparam int FRAME_W    = 24;
  localparam int ENTRY_W    = 21;
  localparam int WEIGHT_W   = 11;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 21;

  // One second in 2^-20 s units, and 1/60 s rounded down
  localparam logic [ENTRY_W-1:0]  ONE_SECOND  = 21'd1048576;
  localparam logic [ENTRY_W-1:0]  RESET_ENTRY = 21'd17476;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 11'd1024;
  localparam logic [31:0]         ROUND_HALF  = 32'd512;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BLEND_WEIGHT   = 2'd0,
    REG_MAX_FRAME_TIME = 2'd1
  } cfg_reg_t;

  // Ring shift control handed from the sequencer to the cell chain
  typedef struct packed {
    logic rotate;  // every cell takes its neighbor, last wraps to first
    logic insert;  // first cell takes a new value, last value drops out
  } ring_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/tmfts_if.sv
// Valid/ready channel interfaces for the smoother's request and result sides.
// Depends on tmfts_pkg for the payload widths.
`default_nettype none

interface tmfts_in_if
  import tmfts_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_time;

  modport source (output valid, output frame_time, input ready);
  modport sink   (input valid, input frame_time, output ready);
endinterface

interface tmfts_out_if
  import tmfts_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] smoothed_time;

  modport source (output valid, output smoothed_time, input ready);
  modport sink   (input valid, input smoothed_time, output ready);
endinterface

`default_nettype wire

FILE: sv/tmfts_cell.sv
// One history cell: a 21-bit entry that loads its neighbor's value on a shift.
// Depends on tmfts_pkg.
`default_nettype none

module tmfts_cell
  import tmfts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               shift,
  input  wire logic [ENTRY_W-1:0] prev_val,
  output logic      [ENTRY_W-1:0] val
);

  logic [ENTRY_W-1:0] val_r;

  // history entries come out of reset at one sixtieth of a second
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= RESET_ENTRY;
    end else if (shift) begin
      val_r <= prev_val;
    end
  end

  assign val = val_r;

endmodule

`default_nettype wire

FILE: sv/tmfts_ring.sv
// Chain of history cells: rotates for a full scan or shifts in a new value.
// Depends on tmfts_pkg and tmfts_cell.
`default_nettype none

module tmfts_ring
  import tmfts_pkg::*;
#(
  parameter int HISTORY_DEPTH = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ring_ctrl_t         ctrl,
  input  wire logic [ENTRY_W-1:0] new_val,
  output logic      [ENTRY_W-1:0] head_val
);

  logic [ENTRY_W-1:0] cell_val [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] first_in;
  logic               shift;

  assign shift    = ctrl.rotate | ctrl.insert;
  // oldest entry sits at the far end; it wraps on rotate, drops on insert
  assign first_in = ctrl.insert ? new_val : cell_val[HISTORY_DEPTH-1];
  assign head_val = cell_val[HISTORY_DEPTH-1];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    tmfts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .prev_val ((i == 0) ? first_in : cell_val[(i == 0) ? 0 : i-1]),
      .val      (cell_val[i])
    );
  end

endmodule

`default_nettype wire

FILE: sv/trimmed_mean_frame_time_smoother_top.sv
// Top level of the trimmed-mean frame time smoother: sequencer and arithmetic.
// Depends on tmfts_pkg, tmfts_if, tmfts_ring and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Each request carries one frame duration (2^-20 s units). It is clamped to
// max_frame_time (itself capped at one second), blended by blend_weight/1024
// with the trimmed mean of the last HISTORY_DEPTH results (sum less one
// minimum and one maximum, divided by HISTORY_DEPTH-2, rounded half up), and
// the blend is pushed into the history and returned. Each request is
// finished before the next one can be taken: the history is a chain of
// cells that is rotated past one accumulator, one entry per cycle, followed
// by a trim, a reciprocal multiply, a correction, the blend multiply, the
// write-back and the idle cycle in which the next request is taken.
// The result waits in an output register; if it is still untaken when the
// next result is ready, the sequencer holds. Configuration writes must be
// made while no request is in flight.
module trimmed_mean_frame_time_smoother_top
  import tmfts_pkg::*;
#(
  parameter int HISTORY_DEPTH = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tmfts_in_if.sink                   in_req,
  tmfts_out_if.source                out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W   = $clog2(HISTORY_DEPTH);
  localparam int SUM_W   = ENTRY_W + $clog2(HISTORY_DEPTH);
  localparam int DIVISOR = HISTORY_DEPTH - 2;
  localparam int HALF    = (HISTORY_DEPTH - 2) / 2;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(HISTORY_DEPTH - 1);
  // floor(2^SUM_W / DIVISOR); quotient estimate is low by at most one
  localparam logic [SUM_W:0]   RECIP    = (SUM_W+1)'((64'd1 << SUM_W) / DIVISOR);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TRIM,
    S_DIV,
    S_FIX,
    S_MUL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [WEIGHT_W-1:0] blend_weight_r;
  logic [ENTRY_W-1:0]  max_frame_time_r;

  // datapath registers
  logic [CNT_W-1:0]    cnt_r;
  logic [ENTRY_W-1:0]  t_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [SUM_W-1:0]    sum_r;
  logic [ENTRY_W-1:0]  lo_r;
  logic [ENTRY_W-1:0]  hi_r;
  logic [SUM_W-1:0]    n_r;
  logic [SUM_W-1:0]    q_r;
  logic [ENTRY_W-1:0]  mean_r;
  logic [31:0]         p_mean_r;
  logic [31:0]         p_t_r;
  logic                out_valid_r;
  logic [ENTRY_W-1:0]  out_data_r;

  logic               accept;
  logic               out_free;
  logic [ENTRY_W-1:0] ceil_eff;
  logic [ENTRY_W-1:0] t_clamp;
  logic [WEIGHT_W-1:0] w_eff;
  logic [ENTRY_W-1:0] head_val;
  ring_ctrl_t         ring_ctrl;
  logic [2*SUM_W:0]   div_prod;
  logic [SUM_W-1:0]   qd;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   mean_fix;
  logic [31:0]        blend_sum;
  logic [21:0]        blend_res;
  logic [ENTRY_W-1:0] res_sat;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;

  // clamp sample and weight against their saturated limits
  assign ceil_eff = (max_frame_time_r > ONE_SECOND) ? ONE_SECOND : max_frame_time_r;
  assign t_clamp  = (in_req.frame_time > FRAME_W'(ceil_eff)) ? ceil_eff
                                                            : in_req.frame_time[ENTRY_W-1:0];
  assign w_eff    = (blend_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_r;

  // division by the trimmed count: reciprocal product, then one correction
  assign div_prod = (2*SUM_W+1)'(n_r) * (2*SUM_W+1)'(RECIP);
  assign qd       = SUM_W'(q_r * SUM_W'(DIVISOR));
  assign rem      = n_r - qd;
  assign mean_fix = (rem >= SUM_W'(DIVISOR)) ? q_r + SUM_W'(1) : q_r;

  // blend rounding, half up
  assign blend_sum = p_mean_r + p_t_r + ROUND_HALF;
  assign blend_res = blend_sum[31:10];
  assign res_sat   = (blend_res > 22'(ONE_SECOND)) ? ONE_SECOND : blend_res[ENTRY_W-1:0];

  // ring control
  always_comb begin
    ring_ctrl        = '0;
    ring_ctrl.rotate = (state_r == S_SCAN);
    ring_ctrl.insert = (state_r == S_DONE) && out_free;
  end

  tmfts_ring #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ring_ctrl),
    .new_val  (res_sat),
    .head_val (head_val)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == LAST_CNT) state_nxt = S_TRIM;
      S_TRIM:  state_nxt = S_DIV;
      S_DIV:   state_nxt = S_FIX;
      S_FIX:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, configuration and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      blend_weight_r   <= 11'd205;
      max_frame_time_r <= ONE_SECOND;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_BLEND_WEIGHT:   blend_weight_r   <= cfg_wdata[WEIGHT_W-1:0];
          REG_MAX_FRAME_TIME: max_frame_time_r <= cfg_wdata[ENTRY_W-1:0];
          default:            ;
        endcase
      end
      if (ring_ctrl.insert) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      t_r   <= t_clamp;
      w_r   <= w_eff;
      cnt_r <= '0;
      sum_r <= '0;
      lo_r  <= '1;
      hi_r  <= '0;
    end
    if (state_r == S_SCAN) begin
      cnt_r <= cnt_r + CNT_W'(1);
      sum_r <= sum_r + SUM_W'(head_val);
      if (head_val < lo_r) lo_r <= head_val;
      if (head_val > hi_r) hi_r <= head_val;
    end
    if (state_r == S_TRIM) begin
      n_r <= sum_r - SUM_W'(lo_r) - SUM_W'(hi_r) + SUM_W'(HALF);
    end
    if (state_r == S_DIV) begin
      q_r <= div_prod[2*SUM_W-1:SUM_W];
    end
    if (state_r == S_FIX) begin
      mean_r <= mean_fix[ENTRY_W-1:0];
    end
    if (state_r == S_MUL) begin
      p_mean_r <= 32'(mean_r) * 32'(WEIGHT_ONE - w_r);
      p_t_r    <= 32'(t_r) * 32'(w_r);
    end
    if (ring_ctrl.insert) begin
      out_data_r <= res_sat;
    end
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.smoothed_time = out_data_r;

  // a full scan visits every cell exactly once, then trims
  `ASSERT_CLKD(a_scan_ends, (state_r == S_SCAN && cnt_r == LAST_CNT) |=> (state_r == S_TRIM), "scan did not end after one pass")
  // a fresh request starts the scan with cleared accumulators
  `ASSERT_CLKD(a_accept_init, accept |=> (state_r == S_SCAN && sum_r == '0 && cnt_r == '0), "scan not initialized on request")
  // after the scan the minimum cannot exceed the maximum
  `ASSERT_CLKD(a_lo_hi, (state_r == S_TRIM) |-> (lo_r <= hi_r), "history minimum above maximum")
  // corrected quotient never exceeds one second
  `ASSERT_CLKD(a_mean_range, (state_r == S_FIX) |-> (mean_fix <= SUM_W'(ONE_SECOND)), "trimmed mean out of range")
  // a result is only written while the output register can take it
  `ASSERT_ALWAYS(a_no_overwrite, (ring_ctrl.insert |-> out_free), "result overwritten before taken")

endmodule

`default_nettype wire

FILE: tb/smoothed_time_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the trimmed-mean frame time smoother: tracks the history ring and
// the configuration, predicts every smoothed_time and checks it. Needs tmfts_pkg and tmfts_if.

module smoothed_time_checker
  import tmfts_pkg::*;
#(
  parameter int HISTORY_DEPTH = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tmfts_in_if                   in_mon,
  tmfts_out_if                  out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    pending,
  output int                    results
);

  localparam int                  MAX_PRINTED  = 40;
  localparam int                  TRIM_DIV     = HISTORY_DEPTH - 2;
  localparam logic [WEIGHT_W-1:0] BLEND_RESET  = 11'd205;

  // Shadow of the block's state
  logic [ENTRY_W-1:0]  history [HISTORY_DEPTH];
  int unsigned         slot;
  logic [WEIGHT_W-1:0] weight_reg;
  logic [ENTRY_W-1:0]  ceiling_reg;

  logic [ENTRY_W-1:0]  expected_smoothed_q [$];
  logic [ENTRY_W-1:0]  want;

  // One line per mismatch (quiet after the first few), always counted
  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches <= mismatches + 1;
  endtask

  // Clamp, trimmed mean of the ring, blend, then push the blend into the ring
  function automatic logic [ENTRY_W-1:0] predict_smoothed(input logic [FRAME_W-1:0] frame);
    logic [63:0] ceiling, sample, w, total, lo, hi, mean, blend;
    ceiling = (ceiling_reg > ONE_SECOND) ? ONE_SECOND : ceiling_reg;
    sample  = (frame > ceiling) ? ceiling : frame;
    w       = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    total   = 0;
    lo      = '1;
    hi      = 0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      total += history[k];
      if (history[k] < lo) lo = history[k];
      if (history[k] > hi) hi = history[k];
    end
    // only one copy of each extreme drops out, even with ties
    mean  = (total - lo - hi + TRIM_DIV / 2) / TRIM_DIV;
    blend = (mean * (WEIGHT_ONE - w) + sample * w + ROUND_HALF) >> 10;
    if (blend > ONE_SECOND) blend = ONE_SECOND;
    slot          = (slot + 1) % HISTORY_DEPTH;
    history[slot] = blend[ENTRY_W-1:0];
    return blend[ENTRY_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (history[k]) history[k] = RESET_ENTRY;
      slot        = 0;
      weight_reg  = BLEND_RESET;
      ceiling_reg = ONE_SECOND;
      expected_smoothed_q.delete();
      mismatches <= 0;
      results    <= 0;
    end else begin
      // register writes; spare indexes are dropped
      if (cfg_we) begin
        if (cfg_addr == REG_BLEND_WEIGHT) weight_reg = cfg_wdata[WEIGHT_W-1:0];
        else if (cfg_addr == REG_MAX_FRAME_TIME) ceiling_reg = cfg_wdata;
      end
      // results first: one taken this edge cannot belong to a request taken this edge
      if (out_mon.valid && out_mon.ready) begin
        results <= results + 1;
        if (expected_smoothed_q.size() == 0) begin
          report_mismatch($sformatf("smoothed_time %0d arrived with nothing pending",
                                    out_mon.smoothed_time));
        end else begin
          want = expected_smoothed_q.pop_front();
          if (out_mon.smoothed_time !== want)
            report_mismatch($sformatf("smoothed_time got %0d, expected %0d",
                                      out_mon.smoothed_time, want));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_smoothed_q.push_back(predict_smoothed(in_mon.frame_time));
    end
    pending <= expected_smoothed_q.size();
  end

endmodule

FILE: tb/tb_trimmed_mean_frame_time_smoother_top.sv
`timescale 1ns / 100ps
// Testbench top for the trimmed-mean frame time smoother: clock, reset, requests,
// register settings and verdict. Needs tmfts_pkg, tmfts_if, the RTL and smoothed_time_checker.

module tb_trimmed_mean_frame_time_smoother_top;
  import tmfts_pkg::*;

  localparam int     HISTORY_DEPTH    = 11;
  localparam int     RANDOM_PHASES    = 8;
  localparam int     FRAMES_PER_PHASE = 135;
  localparam int     SETTLE_CYCLES    = HISTORY_DEPTH + 9;
  localparam int     HOLD_OFF_CYCLES  = 120;
  localparam int     DRAIN_LIMIT      = 20000;
  localparam longint TIMEOUT_NS       = 4_000_000;

  // Indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tmfts_in_if  in_req ();
  tmfts_out_if out_res ();

  int                    mismatches;
  int                    pending;
  int                    results;
  int                    frames_sent      = 0;
  int                    settings_applied = 0;
  bit                    quiet            = 1'b0;
  bit                    hold_off_req     = 1'b0;
  logic [CFG_DATA_W-1:0] cur_ceiling;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trimmed_mean_frame_time_smoother_top #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  smoothed_time_checker #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_req),
    .out_mon   (out_res),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending),
    .results   (results)
  );

  // Offer one frame request, with an occasional idle burst ahead of it
  task automatic offer_frame(input logic [FRAME_W-1:0] frame);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.frame_time <= frame;
    do @(posedge clk); while (!in_req.ready);
    frames_sent++;
  endtask

  // Wait for the block to drain, then program both registers and, if asked, poke the spare indexes
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] weight,
                                input logic [CFG_DATA_W-1:0] ceiling,
                                input bit                    poke_spare);
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BLEND_WEIGHT;
    cfg_wdata <= weight;
    @(posedge clk);
    cfg_addr  <= REG_MAX_FRAME_TIME;
    cfg_wdata <= ceiling;
    @(posedge clk);
    if (poke_spare) begin
      // spare indexes must leave both registers alone
      cfg_addr  <= REG_SPARE_2;
      cfg_wdata <= '1;
      @(posedge clk);
      cfg_addr  <= REG_SPARE_3;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Result side: random ready bursts, one long hold-off on request, none at the end
  initial begin
    out_res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_res.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Request side and verdict
  initial begin
    logic [FRAME_W-1:0]    frame;
    logic [FRAME_W-1:0]    last_frame;
    logic [CFG_DATA_W-1:0] weight;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_addr          <= REG_BLEND_WEIGHT;
    cfg_wdata         <= '0;
    in_req.valid      <= 1'b0;
    in_req.frame_time <= '0;
    cur_ceiling = ONE_SECOND;
    last_frame  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: field extremes, values at and either side of 2^20, alternating bits
    offer_frame(24'd0);
    offer_frame(24'hFFFFFF);
    offer_frame(24'd1048576);
    offer_frame(24'd1048577);
    offer_frame(24'd1048575);
    offer_frame(24'hAAAAAA);
    offer_frame(24'h555555);

    // Full weight with a zero ceiling: everything clamps to zero
    apply_settings(21'd1024, 21'd0, 1'b0);
    offer_frame(24'hFFFFFF);
    offer_frame(24'd5);

    // Weight and ceiling both past their saturation points
    apply_settings(21'd2047, 21'h1FFFFF, 1'b0);
    offer_frame(24'hFFFFFF);
    offer_frame(24'd123456);

    // Zero weight, ceiling of one, spare index writes ignored
    apply_settings(21'd0, 21'd1, 1'b1);
    offer_frame(24'd1);
    offer_frame(24'd2);
    offer_frame(24'd0);

    // Just past one on both
    apply_settings(21'd1025, 21'd1048577, 1'b0);
    offer_frame(24'd1048577);
    offer_frame(24'd1048576);

    // Minimal weight with repeated maximum frames
    apply_settings(21'd1, 21'd1048576, 1'b0);
    offer_frame(24'd1048576);
    offer_frame(24'd1048576);
    offer_frame(24'd1048576);

    // Random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          weight      = 21'd2047;
          cur_ceiling = 21'h1FFFFF;
        end
        1: begin
          weight      = 21'd0;
          cur_ceiling = ONE_SECOND;
        end
        2: begin
          weight      = 21'd1024;
          cur_ceiling = 21'd1;
        end
        3: begin
          weight      = 21'd1;
          cur_ceiling = 21'd0;
        end
        default: begin
          weight      = (p % 2 == 1) ? $urandom_range(0, 1024) : ($urandom & 21'h1FFFFF);
          cur_ceiling = (p % 3 == 0) ? $urandom_range(1, 1048576) : ($urandom & 21'h1FFFFF);
        end
      endcase
      apply_settings(weight, cur_ceiling, p % 2 == 0);
      if (p == RANDOM_PHASES - 1) quiet = 1'b1;
      // fill the block while results are held back
      if (p == 1) hold_off_req = 1'b1;

      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: frame = $urandom_range(0, 24'hFFFFFF);
          4, 5, 6:    frame = $urandom_range(8000, 40000);
          7:          frame = $urandom_range(0, 1048577);
          8: case ($urandom_range(0, 4))
               0:       frame = 24'd0;
               1:       frame = cur_ceiling;
               2:       frame = cur_ceiling + 1;
               3:       frame = 24'hFFFFFF;
               default: frame = ONE_SECOND;
             endcase
          default:    frame = last_frame;
        endcase
        offer_frame(frame);
        last_frame = frame;
      end
    end

    // Drain, then allow for any stray late result
    in_req.valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT; n++) begin
      @(posedge clk);
      if (pending == 0) break;
    end
    repeat (HISTORY_DEPTH + 9) @(posedge clk);

    $display("Checked %0d smoothed results for %0d frame requests under %0d register settings,",
             results, frames_sent, settings_applied);
    $display("with saturated and zero weight and ceiling, spare index writes and a long stall.");
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      if (pending != 0) $display("%0d smoothed results never arrived", pending);
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout after %0d ns with %0d results pending", TIMEOUT_NS, pending);
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/tmfts_pkg.sv
sv/tmfts_if.sv
sv/tmfts_cell.sv
sv/tmfts_ring.sv
sv/trimmed_mean_frame_time_smoother_top.sv
tb/smoothed_time_checker.sv
tb/tb_trimmed_mean_frame_time_smoother_top.sv
